>>> src/lng_pkg.sv
// lng_pkg: shared types, widths and codes for the lattice neighbor generator
// depends on nothing; imported by every module of the block
package lng_pkg;

  // defaults for the top-level limits
  localparam int unsigned MaxSideDef   = 256;
  localparam int unsigned MaxRadiusDef = 3;
  localparam int unsigned MaxGroupDef  = 64;

  // field and register widths
  localparam int unsigned NodeW    = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SideW    = 9;
  localparam int unsigned RadiusW  = 2;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 2;

  // lattice coordinate and clique position widths at the largest limits
  localparam int unsigned CoordW = 8;
  localparam int unsigned PosW   = 6;

  // signed offset width, holds -3 .. +3
  localparam int unsigned OffW = 3;

  // job queue between front and back
  localparam int unsigned JobQDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE,
    CFG_SIDE,
    CFG_RADIUS,
    CFG_GROUP
  } cfg_index_e;

  localparam logic [ModeW-1:0] ModeClique = 2'd0;
  localparam logic [ModeW-1:0] ModeSquare = 2'd1;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_RUN,
    FS_DONE
  } front_state_e;

  typedef enum logic [1:0] {
    JOB_CLIQUE,
    JOB_LATTICE,
    JOB_BAD
  } job_kind_e;

  // effective configuration, limits already applied
  typedef struct packed {
    logic               clique;
    logic               disc;
    logic [SideW-1:0]   side;
    logic [RadiusW-1:0] radius;
    logic [GroupW-1:0]  group;
  } lng_cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    job_kind_e         kind;
    logic [NodeW-1:0]  base;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PosW-1:0]   pos;
  } lng_job_t;

endpackage

>>> src/lattice_neighbor_generator_core.sv
// lattice_neighbor_generator_core: lists the neighbors of one node index
// an item passes the holding register, the divider, the job queue and the back's index pipe
// the back walks one candidate a cycle while the result register is free or being popped;
// the front divides the next item meanwhile; the divider sets the rate of small items
// reset: mode 1, side 16, radius 1, group 4, all queues and registers empty
// depends on lng_pkg, lng_front, lng_job_queue, lng_back
module lattice_neighbor_generator_core #(
  parameter int unsigned MAX_SIDE   = lng_pkg::MaxSideDef,
  parameter int unsigned MAX_RADIUS = lng_pkg::MaxRadiusDef,
  parameter int unsigned MAX_GROUP  = lng_pkg::MaxGroupDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item side
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [lng_pkg::NodeW-1:0]    node_index_i,
  // result side
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [lng_pkg::NodeW-1:0]    neighbor_index_o,
  output logic                         last_o,
  output logic                         bad_index_o,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [lng_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lng_pkg::CfgDataW-1:0] cfg_data_i
);
  import lng_pkg::*;

  // configuration registers
  logic [ModeW-1:0]   mode_q;
  logic [SideW-1:0]   side_q;
  logic [RadiusW-1:0] radius_q;
  logic [GroupW-1:0]  group_q;

  lng_cfg_t cfg;

  // front to queue and queue to back
  lng_job_t front_job, back_job;
  logic job_push, job_full, job_pop, job_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeSquare;
      side_q   <= SideW'(16);
      radius_q <= RadiusW'(1);
      group_q  <= GroupW'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_MODE:   mode_q   <= cfg_data_i[ModeW-1:0];
        CFG_SIDE:   side_q   <= cfg_data_i[SideW-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[RadiusW-1:0];
        CFG_GROUP:  group_q  <= cfg_data_i[GroupW-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective settings: clamp to the limits; mode 3 runs as the disc
  always_comb begin
    cfg.clique = (mode_q == ModeClique);
    cfg.disc   = mode_q[1];
    cfg.side   = (side_q > SideW'(MAX_SIDE)) ? SideW'(MAX_SIDE) : side_q;
    cfg.radius = (radius_q > RadiusW'(MAX_RADIUS)) ? RadiusW'(MAX_RADIUS) : radius_q;
    cfg.group  = (group_q > GroupW'(MAX_GROUP)) ? GroupW'(MAX_GROUP) : group_q;
  end

  // front: holds one item, splits the index by L or G, sorts out bad and empty items
  lng_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .node_index_i (node_index_i),
    .full_o       (full_o),
    .cfg_i        (cfg),
    .job_o        (front_job),
    .job_push_o   (job_push),
    .job_full_i   (job_full)
  );

  // short job queue so the divider runs ahead while the back walks
  lng_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (front_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (back_job),
    .empty_o (job_empty)
  );

  // back: one offset or member a cycle unless a held result stalls, into the result register
  lng_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .job_i            (back_job),
    .job_empty_i      (job_empty),
    .job_pop_o        (job_pop),
    .neighbor_index_o (neighbor_index_o),
    .last_o           (last_o),
    .bad_index_o      (bad_index_o),
    .empty_o          (empty_o),
    .pop_i            (pop_i)
  );

  // a flagged result is always the single, zeroed, final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && bad_index_o) |-> (last_o && (neighbor_index_o == '0)))
    else $error("bad index result not final or not zero");

  // front never hands a job to a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // back only takes a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job taken from empty queue");

endmodule

>>> src/lng_front.sv
// lng_front: input holding register, bit-serial divider and item classification
// depends on lng_pkg
module lng_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [lng_pkg::NodeW-1:0] node_index_i,
  output logic                     full_o,
  input  lng_pkg::lng_cfg_t        cfg_i,
  output lng_pkg::lng_job_t        job_o,
  output logic                     job_push_o,
  input  logic                     job_full_i
);
  import lng_pkg::*;

  localparam int unsigned StepW = $clog2(NodeW);
  localparam logic [StepW-1:0] LastStep = StepW'(NodeW - 1);

  front_state_e state_q, state_d;
  logic in_valid_q, in_valid_d;
  logic [NodeW-1:0] in_node_q;
  logic [NodeW-1:0] node_q, node_d;
  logic [NodeW-1:0] quo_q, quo_d;
  logic [SideW-1:0] rem_q, rem_d;
  logic [SideW-1:0] dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic take;
  logic [SideW:0] partial, diff;
  logic fits;
  logic bad, drop;

  assign full_o = in_valid_q;
  assign in_valid_d = (in_valid_q && !take) || (push_i && !in_valid_q);

  // one quotient bit a step
  always_comb begin
    partial = {rem_q, quo_q[NodeW-1]};
    diff    = partial - {1'b0, dvs_q};
    fits    = partial >= {1'b0, dvs_q};
  end

  // classify the finished division
  always_comb begin
    bad = !cfg_i.clique &&
          ((cfg_i.side == '0) || (quo_q >= {{(NodeW-SideW){1'b0}}, cfg_i.side}));
    drop = cfg_i.clique ? (cfg_i.group < GroupW'(2))
                        : (!bad && (cfg_i.radius == '0));
    job_o.kind = cfg_i.clique ? JOB_CLIQUE : (bad ? JOB_BAD : JOB_LATTICE);
    job_o.base = node_q - {{(NodeW-SideW){1'b0}}, rem_q};
    job_o.x    = rem_q[CoordW-1:0];
    job_o.y    = quo_q[CoordW-1:0];
    job_o.pos  = rem_q[PosW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    step_d     = step_q;
    take       = 1'b0;
    job_push_o = 1'b0;
    unique case (state_q)
      FS_IDLE: begin
        if (in_valid_q) begin
          take    = 1'b1;
          node_d  = in_node_q;
          quo_d   = in_node_q;
          rem_d   = '0;
          dvs_d   = cfg_i.clique ? {{(SideW-GroupW){1'b0}}, cfg_i.group} : cfg_i.side;
          step_d  = '0;
          state_d = FS_RUN;
        end
      end
      FS_RUN: begin
        quo_d  = {quo_q[NodeW-2:0], fits};
        rem_d  = fits ? diff[SideW-1:0] : partial[SideW-1:0];
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = FS_DONE;
        end
      end
      FS_DONE: begin
        if (drop) begin
          state_d = FS_IDLE;
        end else if (!job_full_i) begin
          job_push_o = 1'b1;
          state_d    = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      in_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !in_valid_q) begin
      in_node_q <= node_index_i;
    end
    node_q <= node_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    step_q <= step_d;
  end

endmodule

>>> src/lng_job_queue.sv
// lng_job_queue: short fifo of classified jobs between front and back
// depends on lng_pkg
module lng_job_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lng_pkg::lng_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output lng_pkg::lng_job_t data_o,
  output logic              empty_o
);
  import lng_pkg::*;

  localparam int unsigned PtrW = (JobQDepth > 1) ? $clog2(JobQDepth) : 1;
  localparam int unsigned CntW = $clog2(JobQDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(JobQDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(JobQDepth);

  lng_job_t entry_q [JobQDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/lng_back.sv
// lng_back: walks the offsets or group members of one job, two-stage index pipe
// and the result register; depends on lng_pkg
module lng_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lng_pkg::lng_cfg_t         cfg_i,
  input  lng_pkg::lng_job_t         job_i,
  input  logic                      job_empty_i,
  output logic                      job_pop_o,
  output logic [lng_pkg::NodeW-1:0] neighbor_index_o,
  output logic                      last_o,
  output logic                      bad_index_o,
  output logic                      empty_o,
  input  logic                      pop_i
);
  import lng_pkg::*;

  localparam int unsigned ProdW = SideW + CoordW;

  function automatic logic [3:0] off_sq(input logic [OffW-1:0] d);
    logic [OffW-1:0] neg;
    logic [1:0] mag;
    neg = ~d + 1'b1;
    mag = d[OffW-1] ? neg[1:0] : d[1:0];
    return {2'b00, mag} * {2'b00, mag};
  endfunction

  // (c + d) mod l for c < l and |d| <= 3
  function automatic logic [CoordW-1:0] wrap_coord(input logic [CoordW-1:0] c,
                                                   input logic [OffW-1:0] d,
                                                   input logic [SideW-1:0] l);
    logic signed [SideW+1:0] v;
    logic signed [SideW+1:0] ls;
    v  = $signed({3'b000, c} + {{(SideW+2-OffW){d[OffW-1]}}, d});
    ls = $signed({2'b00, l});
    for (int k = 0; k < 3; k++) begin
      if (v[SideW+1]) v = v + ls;
    end
    for (int k = 0; k < 3; k++) begin
      if (!v[SideW+1] && (v >= ls)) v = v - ls;
    end
    return v[CoordW-1:0];
  endfunction

  logic busy_q, busy_d;
  lng_job_t job_q;
  logic [OffW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [PosW-1:0] j_q, j_d;

  logic s1_valid_q, s1_valid_d;
  logic s1_lat_q, s1_bad_q, s1_last_q;
  logic [NodeW-1:0] s1_idx_q;
  logic [CoordW-1:0] s1_nx_q, s1_ny_q;

  logic out_valid_q;
  logic [NodeW-1:0] out_idx_q;
  logic out_last_q, out_bad_q;

  logic en;
  logic [OffW-1:0] r_s, neg_r;
  logic dx_end, dy_end;
  logic center, outside;
  logic [GroupW-1:0] gm1, gm2, j_ext, pos_ext;
  logic emit, last, done;
  logic [NodeW-1:0] cl_idx;
  logic [CoordW-1:0] nx, ny;
  logic [ProdW-1:0] prod, lat_sum;

  assign en        = !out_valid_q || pop_i;
  assign job_pop_o = !busy_q && !job_empty_i;

  always_comb begin
    r_s     = {1'b0, cfg_i.radius};
    neg_r   = ~r_s + 1'b1;
    dx_end  = (dx_q == r_s);
    dy_end  = (dy_q == r_s);
    center  = (dx_q == '0) && (dy_q == '0);
    outside = cfg_i.disc &&
              (({1'b0, off_sq(dx_q)} + {1'b0, off_sq(dy_q)}) > {1'b0, off_sq(r_s)});
    gm1     = cfg_i.group - GroupW'(1);
    gm2     = cfg_i.group - GroupW'(2);
    j_ext   = {{(GroupW-PosW){1'b0}}, j_q};
    pos_ext = {{(GroupW-PosW){1'b0}}, job_q.pos};
    cl_idx  = job_q.base + {{(NodeW-PosW){1'b0}}, j_q};
    nx      = wrap_coord(job_q.x, dx_q, cfg_i.side);
    ny      = wrap_coord(job_q.y, dy_q, cfg_i.side);

    case (job_q.kind)
      JOB_CLIQUE: begin
        emit = (j_q != job_q.pos);
        done = (j_ext == gm1);
        last = (pos_ext == gm1) ? (j_ext == gm2) : done;
      end
      JOB_LATTICE: begin
        emit = !center && !outside;
        done = dx_end && dy_end;
        last = dx_end && (cfg_i.disc ? (dy_q == '0) : dy_end);
      end
      default: begin
        emit = 1'b1;
        done = 1'b1;
        last = 1'b1;
      end
    endcase
  end

  // walk control
  always_comb begin
    busy_d     = busy_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    j_d        = j_q;
    s1_valid_d = s1_valid_q;
    if (job_pop_o) begin
      busy_d = 1'b1;
      dx_d   = neg_r;
      dy_d   = neg_r;
      j_d    = '0;
    end else if (busy_q && en) begin
      if (done) begin
        busy_d = 1'b0;
      end
      j_d = j_q + 1'b1;
      if (dy_end) begin
        dy_d = neg_r;
        dx_d = dx_q + 1'b1;
      end else begin
        dy_d = dy_q + 1'b1;
      end
    end
    if (en) begin
      s1_valid_d = busy_q && emit;
    end
  end

  always_comb begin
    prod    = cfg_i.side * s1_ny_q;
    lat_sum = prod + {{SideW{1'b0}}, s1_nx_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      s1_valid_q <= s1_valid_d;
      if (en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    dx_q <= dx_d;
    dy_q <= dy_d;
    j_q  <= j_d;
    if (en) begin
      s1_lat_q  <= (job_q.kind == JOB_LATTICE);
      s1_bad_q  <= (job_q.kind == JOB_BAD);
      s1_last_q <= last;
      s1_idx_q  <= cl_idx;
      s1_nx_q   <= nx;
      s1_ny_q   <= ny;
      out_last_q <= s1_last_q;
      out_bad_q  <= s1_bad_q;
      if (s1_lat_q) begin
        out_idx_q <= lat_sum[NodeW-1:0];
      end else if (s1_bad_q) begin
        out_idx_q <= '0;
      end else begin
        out_idx_q <= s1_idx_q;
      end
    end
  end

  assign neighbor_index_o = out_idx_q;
  assign last_o           = out_last_q;
  assign bad_index_o      = out_bad_q;
  assign empty_o          = !out_valid_q;

endmodule
